// ===== sv/two_species_gillespie_step_macros.svh =====
// assertion macros shared by the gillespie step rtl
// expects clk and rst_n in the scope of each use
`ifndef TWO_SPECIES_GILLESPIE_STEP_MACROS_SVH
`define TWO_SPECIES_GILLESPIE_STEP_MACROS_SVH

// same-cycle implication
`define TSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsg_pkg.sv =====
// shared widths, codes, types and helper functions for the gillespie step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

    // field widths
    localparam int RATE_W     = 24;
    localparam int PROB_W     = 16;
    localparam int EXP_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_CNT_W  = 16;
    localparam int CNT_W      = 16;   // cell counter width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RX_W       = 3;
    localparam int STAT_W     = 2;

    // datapath widths
    localparam int PROP_W  = RATE_W + CNT_W;
    localparam int SUM_W   = PROP_W + 3;
    localparam int DVD_W   = EXP_W + FRAC_W;
    localparam int NEXT_W  = DVD_W + 1;
    localparam int CHUNK_W = 24;
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = (CNT_W > CHUNK_W) ? CNT_W : CHUNK_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int NCH     = (SUM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int TSH_W   = NCH * CHUNK_W;
    localparam int UT_W    = SUM_W + PROB_W;
    localparam int STEP_W  = 3;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int NUM_RX  = 5;

    // reaction codes
    localparam logic [RX_W-1:0] RX_BIRTH_ONE = 3'd0;
    localparam logic [RX_W-1:0] RX_BIRTH_TWO = 3'd1;
    localparam logic [RX_W-1:0] RX_DEATH_ONE = 3'd2;
    localparam logic [RX_W-1:0] RX_DEATH_TWO = 3'd3;
    localparam logic [RX_W-1:0] RX_CONVERT   = 3'd4;
    localparam logic [RX_W-1:0] NO_REACTION  = 3'd5;

    // run status codes
    localparam logic [STAT_W-1:0] ST_RUN  = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_TIME = 2'd2;

    // request kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_ONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PROB = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIM  = 3'd6;

    localparam logic [PROB_W-1:0] INIT_PROB_RST = 16'h8000;

    typedef enum logic [1:0] {
        D_HOLD,
        D_INC,
        D_DEC
    } delta_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // count change of type one per reaction
    function automatic delta_t delta_one(input logic [RX_W-1:0] rx);
        delta_t d;
        case (rx)
            RX_BIRTH_ONE: d = D_INC;
            RX_DEATH_ONE: d = D_DEC;
            RX_CONVERT:   d = D_DEC;
            default:      d = D_HOLD;
        endcase
        return d;
    endfunction

    // count change of type two per reaction
    function automatic delta_t delta_two(input logic [RX_W-1:0] rx);
        delta_t d;
        case (rx)
            RX_BIRTH_TWO: d = D_INC;
            RX_DEATH_TWO: d = D_DEC;
            RX_CONVERT:   d = D_INC;
            default:      d = D_HOLD;
        endcase
        return d;
    endfunction

    // saturating count update
    function automatic logic [CNT_W-1:0] apply_delta(input logic [CNT_W-1:0] c,
                                                     input delta_t d);
        logic [CNT_W-1:0] r;
        case (d)
            D_INC:   r = (c == '1) ? c : c + CNT_W'(1);
            D_DEC:   r = (c == '0) ? c : c - CNT_W'(1);
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tsg_mul.sv =====
// shared registered multiplier for propensities and the draw-times-total product
// depends on tsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsg_mul (
    input  wire logic                        clk,
    input  wire logic [tsg_pkg::MUL_A_W-1:0] a,
    input  wire logic [tsg_pkg::MUL_B_W-1:0] b,
    output logic      [tsg_pkg::MUL_P_W-1:0] p
);

    logic [tsg_pkg::MUL_P_W-1:0] p_reg;
    logic [tsg_pkg::MUL_P_W-1:0] p_next;

    // one product per cycle
    always_comb
    begin
        p_next = tsg_pkg::MUL_P_W'(a) * tsg_pkg::MUL_P_W'(b);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== sv/tsg_div.sv =====
// restoring divider, one quotient bit per cycle, for the waiting time
// depends on tsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tsg_pkg::DVD_W-1:0] dividend,
    input  wire logic [tsg_pkg::SUM_W-1:0] divisor,
    output logic      [tsg_pkg::DVD_W-1:0] quotient,
    output tsg_pkg::div_stat_t             stat
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tsg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tsg_pkg::SUM_W-1:0]     rem_reg, rem_next;
    logic [tsg_pkg::DVD_W-1:0]     quo_reg, quo_next;
    logic [tsg_pkg::SUM_W-1:0]     dvs_reg, dvs_next;
    logic [tsg_pkg::SUM_W:0]       trial;
    logic [tsg_pkg::SUM_W:0]       diff;
    logic                          ge;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[tsg_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control and datapath next values
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[tsg_pkg::SUM_W-1:0] : trial[tsg_pkg::SUM_W-1:0];
            quo_next = {quo_reg[tsg_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg + tsg_pkg::DIV_CNT_W'(1);
            if (cnt_reg == tsg_pkg::DIV_CNT_W'(tsg_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== sv/two_species_gillespie_step.sv =====
// Gillespie direct-method step for two cell types and five reactions.
// Input channel (in_valid/in_ready) carries a request: action, uniform_draw,
// exp_draw. Output channel (out_valid/out_ready) carries one result per request:
// counts, elapsed time (Q16.16), reaction fired and finish cause.
// A start request or a step on a finished run goes straight to the output
// register load. A live step runs propensity products on the shared
// multiplier, a total check, the restoring divider (the draw-times-total
// product overlaps it), a time check, serial reaction compares and the output
// register load; it ends after the total check if the total propensity is
// zero, or after the time check if the time limit would be passed.
// in_ready is high only while idle, so a new request is taken at the earliest
// in the cycle after a result is loaded.
// The result sits in an output register; a new request is taken while it waits,
// but a finished request holds in its last state until the output is free.
// Reset clears counts, time, status and the rate registers, and sets the
// initial-choice probability to one half. Configuration writes via cfg_write,
// cfg_index and cfg_data take effect at once, with no handshake.
// depends on tsg_pkg, tsg_mul, tsg_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "two_species_gillespie_step_macros.svh"

module two_species_gillespie_step (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tsg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [tsg_pkg::PROB_W-1:0]     uniform_draw,
    input  wire logic [tsg_pkg::EXP_W-1:0]      exp_draw,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [tsg_pkg::OUT_CNT_W-1:0]  count_one,
    output logic      [tsg_pkg::OUT_CNT_W-1:0]  count_two,
    output logic      [tsg_pkg::TIME_W-1:0]     elapsed_time,
    output logic      [tsg_pkg::RX_W-1:0]       reaction_fired,
    output logic      [tsg_pkg::STAT_W-1:0]     finish_cause
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROP,
        S_TOTAL,
        S_UMUL,
        S_DIVW,
        S_TIME,
        S_PICK,
        S_DONE
    } state_t;

    // configuration registers
    logic [tsg_pkg::RATE_W-1:0] birth_one_reg, birth_two_reg;
    logic [tsg_pkg::RATE_W-1:0] death_one_reg, death_two_reg, convert_reg;
    logic [tsg_pkg::PROB_W-1:0] init_prob_reg;
    logic [tsg_pkg::TIME_W-1:0] time_limit_reg;

    // control and run state
    state_t                      state_reg, state_next;
    logic [tsg_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [tsg_pkg::CNT_W-1:0]   cells_one_reg, cells_one_next;
    logic [tsg_pkg::CNT_W-1:0]   cells_two_reg, cells_two_next;
    logic [tsg_pkg::TIME_W-1:0]  sim_time_reg, sim_time_next;
    logic [tsg_pkg::STAT_W-1:0]  run_status_reg, run_status_next;
    logic [tsg_pkg::RX_W-1:0]    fired_reg, fired_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tsg_pkg::CNT_W-1:0]   oc1_reg, oc1_next;
    logic [tsg_pkg::CNT_W-1:0]   oc2_reg, oc2_next;
    logic [tsg_pkg::TIME_W-1:0]  otime_reg, otime_next;
    logic [tsg_pkg::RX_W-1:0]    ofired_reg, ofired_next;
    logic [tsg_pkg::STAT_W-1:0]  ocause_reg, ocause_next;

    // datapath registers
    logic [tsg_pkg::PROB_W-1:0] u_reg, u_next;
    logic [tsg_pkg::EXP_W-1:0]  e_reg, e_next;
    logic [tsg_pkg::SUM_W-1:0]  run_sum_reg, run_sum_next;
    logic [tsg_pkg::SUM_W-1:0]  sums_reg [tsg_pkg::NUM_RX];
    logic [tsg_pkg::SUM_W-1:0]  sums_next [tsg_pkg::NUM_RX];
    logic [tsg_pkg::TSH_W-1:0]  tshift_reg, tshift_next;
    logic [tsg_pkg::UT_W-1:0]   acc_reg, acc_next;
    logic [tsg_pkg::TIME_W-1:0] next_time_reg, next_time_next;

    // shared units
    logic [tsg_pkg::MUL_A_W-1:0] mul_a;
    logic [tsg_pkg::MUL_B_W-1:0] mul_b;
    logic [tsg_pkg::MUL_P_W-1:0] mul_p;
    logic                        div_start;
    logic [tsg_pkg::DVD_W-1:0]   div_quo;
    tsg_pkg::div_stat_t          div_stat;

    logic [tsg_pkg::NEXT_W-1:0]  time_sum;
    logic [tsg_pkg::SUM_W-1:0]   step_sum;
    logic [tsg_pkg::UT_W-1:0]    pick_ref;
    logic                        below;
    logic                        in_fire;
    logic                        out_free;
    logic [tsg_pkg::RX_W-1:0]    rx_cur;

    tsg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({e_reg, {tsg_pkg::FRAC_W{1'b0}}}),
        .divisor  (run_sum_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_one_reg  <= '0;
            birth_two_reg  <= '0;
            death_one_reg  <= '0;
            death_two_reg  <= '0;
            convert_reg    <= '0;
            init_prob_reg  <= tsg_pkg::INIT_PROB_RST;
            time_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tsg_pkg::CFG_BIRTH_ONE: birth_one_reg  <= cfg_data[tsg_pkg::RATE_W-1:0];
                tsg_pkg::CFG_BIRTH_TWO: birth_two_reg  <= cfg_data[tsg_pkg::RATE_W-1:0];
                tsg_pkg::CFG_DEATH_ONE: death_one_reg  <= cfg_data[tsg_pkg::RATE_W-1:0];
                tsg_pkg::CFG_DEATH_TWO: death_two_reg  <= cfg_data[tsg_pkg::RATE_W-1:0];
                tsg_pkg::CFG_CONVERT:   convert_reg    <= cfg_data[tsg_pkg::RATE_W-1:0];
                tsg_pkg::CFG_INIT_PROB: init_prob_reg  <= cfg_data[tsg_pkg::PROB_W-1:0];
                tsg_pkg::CFG_TIME_LIM:  time_limit_reg <= cfg_data[tsg_pkg::TIME_W-1:0];
                default:                ;
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_PROP)
        begin
            case (cnt_reg)
                tsg_pkg::RX_BIRTH_ONE:
                begin
                    mul_a = birth_one_reg;
                    mul_b = tsg_pkg::MUL_B_W'(cells_one_reg);
                end
                tsg_pkg::RX_BIRTH_TWO:
                begin
                    mul_a = birth_two_reg;
                    mul_b = tsg_pkg::MUL_B_W'(cells_two_reg);
                end
                tsg_pkg::RX_DEATH_ONE:
                begin
                    mul_a = death_one_reg;
                    mul_b = tsg_pkg::MUL_B_W'(cells_one_reg);
                end
                tsg_pkg::RX_DEATH_TWO:
                begin
                    mul_a = death_two_reg;
                    mul_b = tsg_pkg::MUL_B_W'(cells_two_reg);
                end
                tsg_pkg::RX_CONVERT:
                begin
                    mul_a = convert_reg;
                    mul_b = tsg_pkg::MUL_B_W'(cells_one_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_UMUL)
        begin
            mul_a = tsg_pkg::MUL_A_W'(u_reg);
            mul_b = tsg_pkg::MUL_B_W'(tshift_reg[tsg_pkg::TSH_W-1 -: tsg_pkg::CHUNK_W]);
        end
    end

    // shared adders and comparators
    always_comb
    begin
        in_fire  = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        step_sum = run_sum_reg + tsg_pkg::SUM_W'(mul_p);
        time_sum = tsg_pkg::NEXT_W'(sim_time_reg) + tsg_pkg::NEXT_W'(div_quo);
        rx_cur   = cnt_reg;
        pick_ref = {sums_reg[cnt_reg], {tsg_pkg::FRAC_W{1'b0}}};
        below    = (acc_reg < pick_ref);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cells_one_next  = cells_one_reg;
        cells_two_next  = cells_two_reg;
        sim_time_next   = sim_time_reg;
        run_status_next = run_status_reg;
        fired_next      = fired_reg;
        out_valid_next  = out_valid_reg;
        oc1_next        = oc1_reg;
        oc2_next        = oc2_reg;
        otime_next      = otime_reg;
        ofired_next     = ofired_reg;
        ocause_next     = ocause_reg;
        u_next          = u_reg;
        e_next          = e_reg;
        run_sum_next    = run_sum_reg;
        sums_next       = sums_reg;
        tshift_next     = tshift_reg;
        acc_next        = acc_reg;
        next_time_next  = next_time_reg;
        div_start       = 1'b0;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    u_next     = uniform_draw;
                    e_next     = exp_draw;
                    fired_next = tsg_pkg::NO_REACTION;
                    if (action == tsg_pkg::ACT_START)
                    begin
                        if (uniform_draw < init_prob_reg)
                        begin
                            cells_one_next = tsg_pkg::CNT_W'(1);
                            cells_two_next = '0;
                        end
                        else
                        begin
                            cells_one_next = '0;
                            cells_two_next = tsg_pkg::CNT_W'(1);
                        end
                        sim_time_next   = '0;
                        run_status_next = tsg_pkg::ST_RUN;
                        state_next      = S_DONE;
                    end
                    else if (run_status_reg != tsg_pkg::ST_RUN)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        run_sum_next = '0;
                        cnt_next     = '0;
                        state_next   = S_PROP;
                    end
                end
            end
            // products issue on counts 0..4, each sum lands in the following cycle
            S_PROP:
            begin
                if (cnt_reg != '0)
                begin
                    run_sum_next                 = step_sum;
                    sums_next[cnt_reg - 3'd1]    = step_sum;
                end
                if (cnt_reg == tsg_pkg::STEP_W'(tsg_pkg::NUM_RX))
                begin
                    state_next = S_TOTAL;
                end
                else
                begin
                    cnt_next = cnt_reg + tsg_pkg::STEP_W'(1);
                end
            end
            S_TOTAL:
            begin
                if (run_sum_reg == '0)
                begin
                    run_status_next = tsg_pkg::ST_ZERO;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_start   = 1'b1;
                    tshift_next = tsg_pkg::TSH_W'(run_sum_reg);
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_UMUL;
                end
            end
            // draw times total, top chunk first, while the divider runs
            S_UMUL:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = (acc_reg << tsg_pkg::CHUNK_W) + tsg_pkg::UT_W'(mul_p);
                end
                tshift_next = tshift_reg << tsg_pkg::CHUNK_W;
                if (cnt_reg == tsg_pkg::STEP_W'(tsg_pkg::NCH))
                begin
                    state_next = S_DIVW;
                end
                else
                begin
                    cnt_next = cnt_reg + tsg_pkg::STEP_W'(1);
                end
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                if (time_sum > tsg_pkg::NEXT_W'(time_limit_reg))
                begin
                    run_status_next = tsg_pkg::ST_TIME;
                    state_next      = S_DONE;
                end
                else
                begin
                    next_time_next = time_sum[tsg_pkg::TIME_W-1:0];
                    cnt_next       = '0;
                    state_next     = S_PICK;
                end
            end
            // first running sum above the scaled draw wins, else the last reaction
            S_PICK:
            begin
                if (below || cnt_reg == tsg_pkg::STEP_W'(tsg_pkg::NUM_RX - 1))
                begin
                    cells_one_next = tsg_pkg::apply_delta(cells_one_reg,
                                                          tsg_pkg::delta_one(rx_cur));
                    cells_two_next = tsg_pkg::apply_delta(cells_two_reg,
                                                          tsg_pkg::delta_two(rx_cur));
                    sim_time_next  = next_time_reg;
                    fired_next     = rx_cur;
                    state_next     = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + tsg_pkg::STEP_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oc1_next       = cells_one_reg;
                    oc2_next       = cells_two_reg;
                    otime_next     = sim_time_reg;
                    ofired_next    = fired_reg;
                    ocause_next    = run_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            cells_one_reg  <= '0;
            cells_two_reg  <= '0;
            sim_time_reg   <= '0;
            run_status_reg <= tsg_pkg::ST_RUN;
            fired_reg      <= tsg_pkg::NO_REACTION;
            out_valid_reg  <= 1'b0;
            oc1_reg        <= '0;
            oc2_reg        <= '0;
            otime_reg      <= '0;
            ofired_reg     <= tsg_pkg::NO_REACTION;
            ocause_reg     <= tsg_pkg::ST_RUN;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cells_one_reg  <= cells_one_next;
            cells_two_reg  <= cells_two_next;
            sim_time_reg   <= sim_time_next;
            run_status_reg <= run_status_next;
            fired_reg      <= fired_next;
            out_valid_reg  <= out_valid_next;
            oc1_reg        <= oc1_next;
            oc2_reg        <= oc2_next;
            otime_reg      <= otime_next;
            ofired_reg     <= ofired_next;
            ocause_reg     <= ocause_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        e_reg         <= e_next;
        run_sum_reg   <= run_sum_next;
        sums_reg      <= sums_next;
        tshift_reg    <= tshift_next;
        acc_reg       <= acc_next;
        next_time_reg <= next_time_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign count_one      = tsg_pkg::OUT_CNT_W'(oc1_reg);
    assign count_two      = tsg_pkg::OUT_CNT_W'(oc2_reg);
    assign elapsed_time   = otime_reg;
    assign reaction_fired = ofired_reg;
    assign finish_cause   = ocause_reg;

    // checks
    `TSG_ASSERT_NEXT(a_finished_holds_one,
        in_fire && action == tsg_pkg::ACT_STEP && run_status_reg != tsg_pkg::ST_RUN,
        $stable(cells_one_reg) && $stable(sim_time_reg),
        "step on a finished run changed the state")
    `TSG_ASSERT_NOW(a_div_done_in_wait,
        div_stat.done,
        state_reg == S_DIVW,
        "divider finished outside its wait state")
    `TSG_ASSERT_NOW(a_fired_means_running,
        out_valid && reaction_fired != tsg_pkg::NO_REACTION,
        finish_cause == tsg_pkg::ST_RUN,
        "reaction reported on a finished run")

endmodule

`default_nettype wire
